[rtl/core/slot_alloc_pkg.sv]
// Shared field widths, codes and control structures of the slot allocator.
package slot_alloc_pkg;

	localparam int FUNC_W      = 1;
	localparam int SLOT_W      = 4;
	localparam int STATUS_W    = 3;
	localparam int ID_W        = 16;
	localparam int WAITERS_W   = 5;
	localparam int CFG_W       = 4;
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 48;
	localparam int OUT_PAD_W   = OUT_TDATA_W - (SLOT_W + 2 * ID_W + WAITERS_W);

	localparam logic [CFG_W-1:0] CFG_RESET = 4'd5;

	localparam logic [FUNC_W-1:0] FUNC_RESERVE = 1'b0;
	localparam logic [FUNC_W-1:0] FUNC_CANCEL  = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		STAT_SEATED     = 3'd0,
		STAT_WAITLISTED = 3'd1,
		STAT_REJECTED   = 3'd2,
		STAT_INVALID    = 3'd3,
		STAT_NOT_BOOKED = 3'd4,
		STAT_CANCELLED  = 3'd5
	} status_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic lookup;
		logic commit;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_free;
	} dp_stat_t;

endpackage

[rtl/core/slot_alloc_ctrl.sv]
// Controller state machine of the slot allocator: capture, look up, commit.
module slot_alloc_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  slot_alloc_pkg::dp_stat_t stat,
	output slot_alloc_pkg::dp_cmd_t  cmd
);
	import slot_alloc_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_LOOK   = 3'b010,
		S_COMMIT = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;

	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = S_LOOK;
				end
			end
			S_LOOK: begin
				cmd.lookup = 1'b1;
				state_d    = S_COMMIT;
			end
			S_COMMIT: begin
				// Wait here until the output register can take the result.
				if (stat.out_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef ASSERT_OFF
	// Every accepted request moves on to the lookup state; commit follows once the output register has room.
	a_load_then_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> cmd.lookup)
		else $error("lookup did not follow an accepted request");

	a_commit_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> stat.out_free)
		else $error("commit issued while the output register was occupied");

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.lookup, cmd.commit}))
		else $error("more than one datapath command in a cycle");
`endif

endmodule

[rtl/core/slot_alloc_dp.sv]
// Datapath of the slot allocator: slot owners, waitlist FIFO, id counter, result register.
module slot_alloc_dp #(
	parameter int SLOTS      = 8,
	parameter int WAIT_DEPTH = 16,
	parameter int ID_BITS    = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [slot_alloc_pkg::CFG_W-1:0]       cfg_wdata,
	input  logic [slot_alloc_pkg::FUNC_W-1:0]      in_func,
	input  logic [slot_alloc_pkg::SLOT_W-1:0]      in_slot,
	input  slot_alloc_pkg::dp_cmd_t                cmd,
	output slot_alloc_pkg::dp_stat_t               stat,
	input  logic                                   m_tready,
	output logic                                   m_tvalid,
	output logic [slot_alloc_pkg::STATUS_W-1:0]    m_tuser,
	output logic [slot_alloc_pkg::OUT_TDATA_W-1:0] m_tdata
);
	import slot_alloc_pkg::*;

	localparam int SIW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int WPW = $clog2(WAIT_DEPTH);
	localparam int CW  = $clog2(WAIT_DEPTH + 1);

	// Configuration and control state
	logic [CFG_W-1:0]   cfg_q;
	logic [ID_BITS-1:0] owner_q [SLOTS];
	logic [WPW-1:0]     head_q;
	logic [WPW-1:0]     tail_q;
	logic [CW-1:0]      count_q;
	logic [ID_BITS-1:0] next_id_q;
	logic [ID_BITS-1:0] wait_mem [WAIT_DEPTH];

	// Captured request
	logic [FUNC_W-1:0]  func_s1;
	logic [SLOT_W-1:0]  slot_s1;

	// Lookup results
	logic [FUNC_W-1:0]  func_s2;
	logic [SLOT_W-1:0]  slot_s2;
	logic               slot_ok_s2;
	logic [SIW-1:0]     cidx_s2;
	logic [ID_BITS-1:0] owner_s2;
	logic               free_hit_s2;
	logic [SIW-1:0]     free_idx_s2;
	logic [ID_BITS-1:0] head_data_s2;

	// Result register
	logic               out_valid_q;
	status_t            out_status_q;
	logic [SLOT_W-1:0]  out_slot_q;
	logic [ID_W-1:0]    out_gid_q;
	logic [ID_W-1:0]    out_cid_q;
	logic [WAITERS_W-1:0] out_waiters_q;

	// Combinational signals
	logic [SLOTS-1:0]   free_vec;
	logic               free_hit;
	logic [SIW-1:0]     free_idx;
	logic               slot_ok;
	logic [SIW-1:0]     cidx;

	status_t            res_status;
	logic [SLOT_W-1:0]  res_slot;
	logic [ID_BITS-1:0] res_gid;
	logic [ID_BITS-1:0] res_cid;
	logic               push;
	logic               pop;
	logic               advance;
	logic               owner_we;
	logic [SIW-1:0]     owner_widx;
	logic [ID_BITS-1:0] owner_wdata;
	logic [CW-1:0]      count_next;

	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			free_vec[i] = (i < int'(cfg_q)) && (owner_q[i] == '0);
		end
	end

	// Lowest free enabled slot
	always_comb begin
		free_hit = 1'b0;
		free_idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (free_vec[i]) begin
				free_hit = 1'b1;
				free_idx = SIW'(i);
			end
		end
	end

	assign slot_ok = (slot_s1 != '0) && (int'(slot_s1) <= int'(cfg_q))
		&& (int'(slot_s1) <= SLOTS);
	assign cidx    = SIW'(slot_s1 - SLOT_W'(1));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_s1 <= in_func;
			slot_s1 <= in_slot;
		end
		if (cmd.lookup) begin
			func_s2      <= func_s1;
			slot_s2      <= slot_s1;
			slot_ok_s2   <= slot_ok;
			cidx_s2      <= cidx;
			owner_s2     <= slot_ok ? owner_q[cidx] : '0;
			free_hit_s2  <= free_hit;
			free_idx_s2  <= free_idx;
			head_data_s2 <= wait_mem[head_q];
		end
		if (cmd.commit && push) begin
			wait_mem[tail_q] <= next_id_q;
		end
	end

	always_comb begin
		res_status  = STAT_REJECTED;
		res_slot    = '0;
		res_gid     = '0;
		res_cid     = '0;
		push        = 1'b0;
		pop         = 1'b0;
		advance     = 1'b0;
		owner_we    = 1'b0;
		owner_widx  = free_idx_s2;
		owner_wdata = next_id_q;
		if (func_s2 == FUNC_RESERVE) begin
			priority if (free_hit_s2) begin
				owner_we   = 1'b1;
				res_status = STAT_SEATED;
				res_slot   = SLOT_W'(free_idx_s2) + SLOT_W'(1);
				res_gid    = next_id_q;
				advance    = 1'b1;
			end else if (count_q < CW'(WAIT_DEPTH)) begin
				push       = 1'b1;
				res_status = STAT_WAITLISTED;
				res_gid    = next_id_q;
				advance    = 1'b1;
			end else begin
				res_status = STAT_REJECTED;
			end
		end else begin
			priority if (!slot_ok_s2) begin
				res_status = STAT_INVALID;
			end else if (owner_s2 == '0) begin
				res_status = STAT_NOT_BOOKED;
			end else begin
				res_status = STAT_CANCELLED;
				res_cid    = owner_s2;
				owner_we   = 1'b1;
				owner_widx = cidx_s2;
				if (count_q != '0) begin
					// The oldest waiter takes over the released slot.
					pop         = 1'b1;
					owner_wdata = head_data_s2;
					res_slot    = slot_s2;
					res_gid     = head_data_s2;
				end else begin
					owner_wdata = '0;
				end
			end
		end
	end

	assign count_next = count_q + CW'(push) - CW'(pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q     <= CFG_RESET;
			head_q    <= '0;
			tail_q    <= '0;
			count_q   <= '0;
			next_id_q <= ID_BITS'(1);
			for (int i = 0; i < SLOTS; i++) begin
				owner_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				cfg_q <= cfg_wdata;
			end
			if (cmd.commit) begin
				if (owner_we) begin
					owner_q[owner_widx] <= owner_wdata;
				end
				if (push) begin
					tail_q <= (tail_q == WPW'(WAIT_DEPTH - 1)) ? '0 : tail_q + WPW'(1);
				end
				if (pop) begin
					head_q <= (head_q == WPW'(WAIT_DEPTH - 1)) ? '0 : head_q + WPW'(1);
				end
				count_q <= count_next;
				if (advance) begin
					next_id_q <= (next_id_q == {ID_BITS{1'b1}}) ? ID_BITS'(1)
						: next_id_q + ID_BITS'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_status_q  <= res_status;
			out_slot_q    <= res_slot;
			out_gid_q     <= ID_W'(res_gid);
			out_cid_q     <= ID_W'(res_cid);
			out_waiters_q <= WAITERS_W'(count_next);
		end
	end

	assign stat.out_free = !out_valid_q || m_tready;
	assign m_tvalid      = out_valid_q;
	assign m_tuser       = out_status_q;
	assign m_tdata       = {{OUT_PAD_W{1'b0}}, out_waiters_q, out_cid_q, out_gid_q, out_slot_q};

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(WAIT_DEPTH))
		else $error("waitlist count beyond its depth");

	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (head_q == tail_q))
		else $error("empty waitlist with differing pointers");

	a_id_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		next_id_q != '0)
		else $error("request id counter reached zero");

	a_result_from_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.commit))
		else $error("result appeared without a commit");
`endif

endmodule

[rtl/core/slot_allocator_with_fifo_waitlist.sv]
// Top level of the slot allocator with a FIFO waitlist.
// Each request on the slave stream is either a reserve (tuser 0) or a cancel
// (tuser 1) of the one-based slot in tdata. A reserve seats a fresh request id
// in the lowest free enabled slot; with no slot free the id joins a circular
// FIFO waitlist, and with that list full too the request is rejected without
// using an id. A cancel of a booked slot hands the slot to the oldest waiter,
// or frees it when nobody waits. Ids count from 1 up to all ones and wrap to
// 1, so id 0 always means none. Every request yields exactly one result on the
// master stream. A request is captured in the idle state that accepts it,
// looked up in the lookup state (the registered read of the waitlist head
// and the search for the lowest free slot) and committed in the commit
// state, which waits until the output register can take the result; the
// next request is accepted only once the controller is back in its idle
// state, so requests are handled one at a time and do not overlap. The
// output register lets a new request be accepted while the previous result
// still waits to be taken. The slot count register is written through
// cfg_we/cfg_wdata and resets to five enabled slots; values above SLOTS act
// as SLOTS. The waitlist store needs no clearing pass after reset, so
// requests are taken from the first cycle.
module slot_allocator_with_fifo_waitlist #(
	parameter int SLOTS      = 8,
	parameter int WAIT_DEPTH = 16,
	parameter int ID_BITS    = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// Slot count register write
	input  logic                                   cfg_we,
	input  logic [slot_alloc_pkg::CFG_W-1:0]       cfg_wdata,   // slots_in_use
	// Request stream
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	input  logic [slot_alloc_pkg::IN_TDATA_W-1:0]  s_tdata,     // [3:0] slot_number
	input  logic [slot_alloc_pkg::FUNC_W-1:0]      s_tuser,     // [0] func
	// Result stream
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	// [3:0] slot_granted, [19:4] granted_id, [35:20] cancelled_id, [40:36] waiters
	output logic [slot_alloc_pkg::OUT_TDATA_W-1:0] m_tdata,
	output logic [slot_alloc_pkg::STATUS_W-1:0]    m_tuser      // [2:0] status
);
	import slot_alloc_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// Sequencing of one request at a time through capture, lookup and commit.
	slot_alloc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Slot owners, waitlist, id counter and the result register.
	slot_alloc_dp #(
		.SLOTS      (SLOTS),
		.WAIT_DEPTH (WAIT_DEPTH),
		.ID_BITS    (ID_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_func   (s_tuser),
		.in_slot   (s_tdata[SLOT_W-1:0]),
		.cmd       (cmd),
		.stat      (stat),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tuser   (m_tuser),
		.m_tdata   (m_tdata)
	);

endmodule

[test/tb_slot_allocator_with_fifo_waitlist.sv]
// Self-checking stream testbench for the slot allocator with its FIFO waitlist.
module tb_slot_allocator_with_fifo_waitlist;
	timeunit 1ns;
	timeprecision 1ps;

	import slot_alloc_pkg::*;

	// Build of the block under test; the predictor below is sized to match.
	localparam int SLOTS       = 8;
	localparam int WAIT_DEPTH  = 16;
	localparam int ID_BITS     = 16;
	localparam int CLK_PERIOD  = 10;
	// Spare cycles after the last result, so the block is idle again before
	// touching the slot count register or ending the run.
	localparam int SETTLE_CYCLES = 6;
	// Long receiver hold-off, long enough for the request side to back up.
	localparam int HOLD_CYCLES = 120;
	// Mismatches beyond this many are counted but not printed.
	localparam int REPORT_CAP = 40;
	// Watchdog limit, well above the length of the whole run with the
	// heaviest idling.
	localparam int CYCLE_LIMIT = 100_000;

	// One request as the sender holds it before it is offered.
	typedef struct {
		logic [FUNC_W-1:0] func;
		logic [SLOT_W-1:0] slot;
	} req_t;

	// One result as the allocator should report it.
	typedef struct {
		status_t             status;
		logic [SLOT_W-1:0]   slot_granted;
		logic [ID_W-1:0]     granted_id;
		logic [ID_W-1:0]     cancelled_id;
		logic [WAITERS_W-1:0] waiters;
	} booking_t;

	// Clock, reset and every block input start at known values.
	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   cfg_we    = 1'b0;
	logic [CFG_W-1:0]       cfg_wdata = CFG_RESET;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata   = '0;
	logic [FUNC_W-1:0]      s_tuser   = FUNC_RESERVE;
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic [STATUS_W-1:0]    m_tuser;

	slot_allocator_with_fifo_waitlist #(
		.SLOTS      (SLOTS),
		.WAIT_DEPTH (WAIT_DEPTH),
		.ID_BITS    (ID_BITS)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Requests waiting to be offered, and results owed by the allocator in
	// order of acceptance.
	req_t     pending_reqs[$];
	booking_t results_due[$];

	// Idling knobs, in percent, set per phase by the sequencer.
	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;

	// Predicted allocator state, kept in step with every accepted request.
	logic [CFG_W-1:0] slots_cfg;
	logic [ID_W-1:0]  seat_owner [SLOTS];
	logic [ID_W-1:0]  wait_ids   [WAIT_DEPTH];
	int               wait_rd;
	int               wait_wr;
	int               wait_len;
	logic [ID_W-1:0]  id_next;

	// Run statistics and failure count.
	int n_fail       = 0;
	int n_checked    = 0;
	int n_in_stalls  = 0;
	int n_cfg_writes = 0;
	int n_status [6];
	int cycles       = 0;

	// Hands out the next request id and advances the counter, which skips
	// zero on its way round because zero means "nobody".
	function automatic logic [ID_W-1:0] take_id();
		logic [ID_W-1:0] id;
		id = id_next;
		if (id_next == '1) begin
			id_next = ID_W'(1);
		end else begin
			id_next = id_next + ID_W'(1);
		end
		return id;
	endfunction

	// Applies one request to the predicted state and returns the result the
	// allocator owes for it.
	function automatic booking_t book_request(input logic [FUNC_W-1:0] func,
	                                          input logic [SLOT_W-1:0] slot);
		booking_t r;
		int       enabled;
		bit       seated;
		r.status       = STAT_SEATED;
		r.slot_granted = '0;
		r.granted_id   = '0;
		r.cancelled_id = '0;
		seated         = 1'b0;
		// Register values above the build simply enable every slot.
		enabled = (slots_cfg > SLOTS) ? SLOTS : int'(slots_cfg);
		if (func == FUNC_RESERVE) begin
			// Lowest free enabled slot wins; slots beyond the enabled count are
			// never handed out, even if free.
			for (int i = 0; i < enabled && !seated; i++) begin
				if (seat_owner[i] == '0) begin
					seat_owner[i]  = take_id();
					r.slot_granted = SLOT_W'(i + 1);
					r.granted_id   = seat_owner[i];
					seated         = 1'b1;
				end
			end
			if (!seated) begin
				if (wait_len < WAIT_DEPTH) begin
					wait_ids[wait_wr] = id_next;
					r.granted_id = take_id();
					wait_wr      = (wait_wr + 1) % WAIT_DEPTH;
					wait_len++;
					r.status     = STAT_WAITLISTED;
				end else begin
					// Waitlist full: the request is turned away and no id is spent.
					r.status = STAT_REJECTED;
				end
			end
		end else begin
			if (slot == '0 || int'(slot) > enabled) begin
				r.status = STAT_INVALID;
			end else if (seat_owner[slot - 1] == '0) begin
				r.status = STAT_NOT_BOOKED;
			end else begin
				r.status       = STAT_CANCELLED;
				r.cancelled_id = seat_owner[slot - 1];
				if (wait_len > 0) begin
					// The oldest waiter takes over the released slot.
					seat_owner[slot - 1] = wait_ids[wait_rd];
					r.slot_granted       = slot;
					r.granted_id         = wait_ids[wait_rd];
					wait_rd              = (wait_rd + 1) % WAIT_DEPTH;
					wait_len--;
				end else begin
					seat_owner[slot - 1] = '0;
				end
			end
		end
		r.waiters = WAITERS_W'(wait_len);
		return r;
	endfunction

	// Request driver: predicts the result of each accepted request, then
	// offers the next pending one unless this cycle is chosen to idle.
	req_t     next_req;
	booking_t booked;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= FUNC_RESERVE;
		end else begin
			if (s_tvalid && s_tready) begin
				booked = book_request(s_tuser, s_tdata[SLOT_W-1:0]);
				results_due.push_back(booked);
			end
			if (s_tvalid && !s_tready)
				n_in_stalls++;
			// A request stays on the bus until taken; only then may the next
			// one replace it, or the bus fall idle.
			if (!s_tvalid || s_tready) begin
				if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_req = pending_reqs.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= IN_TDATA_W'(next_req.slot);
					s_tuser  <= next_req.func;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold-off, counted down in its own process. The sequencer
	// asks for one by bumping hold_asks.
	int hold_asks  = 0;
	int hold_taken = 0;
	int hold_left  = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left  <= 0;
			hold_taken <= 0;
		end else if (hold_asks != hold_taken) begin
			hold_taken <= hold_asks;
			hold_left  <= HOLD_CYCLES;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	task automatic check_field(input string name, input int unsigned want,
	                           input int unsigned got);
		if (want != got) begin
			n_fail++;
			if (n_fail <= REPORT_CAP)
				$error("%s mismatch: expected %0d, got %0d", name, want, got);
		end
	endtask

	// Result monitor: every accepted result is checked against the oldest
	// outstanding prediction, field by field.
	booking_t due;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (results_due.size() == 0) begin
					n_fail++;
					if (n_fail <= REPORT_CAP)
						$error("result with no request outstanding");
				end else begin
					due = results_due.pop_front();
					n_checked++;
					n_status[int'(due.status)]++;
					check_field("status", due.status, m_tuser);
					check_field("slot_granted", due.slot_granted,
						m_tdata[SLOT_W-1:0]);
					check_field("granted_id", due.granted_id,
						m_tdata[SLOT_W +: ID_W]);
					check_field("cancelled_id", due.cancelled_id,
						m_tdata[SLOT_W+ID_W +: ID_W]);
					check_field("waiters", due.waiters,
						m_tdata[SLOT_W+2*ID_W +: WAITERS_W]);
				end
			end
			m_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$error("run did not finish within %0d cycles", CYCLE_LIMIT);
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic add_req(input logic [FUNC_W-1:0] func, input int slot);
		req_t r;
		r.func = func;
		r.slot = SLOT_W'(slot);
		pending_reqs.push_back(r);
	endtask

	// Waits until every request has been taken and every result has come back,
	// then lets the pipeline settle.
	task automatic drain();
		@(negedge clk);
		while (pending_reqs.size() != 0 || s_tvalid || results_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Writes the slot count register with the allocator idle, keeping the
	// predictor in step. Ends on a falling edge so later queue pushes never
	// share a time step with the driver.
	task automatic set_slots(input int value);
		drain();
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= CFG_W'(value);
		slots_cfg  = CFG_W'(value);
		@(posedge clk);
		cfg_we <= 1'b0;
		n_cfg_writes++;
		@(negedge clk);
	endtask

	// Queues random traffic. Most cancels name an enabled slot, so bookings
	// really move between ids and the waitlist; the rest aim anywhere in the
	// field, which also covers slot zero and slots beyond the enabled count.
	task automatic add_random(input int count, input int reserve_pct);
		int enabled;
		int slot;
		enabled = (slots_cfg > SLOTS) ? SLOTS : int'(slots_cfg);
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(99) < reserve_pct) begin
				add_req(FUNC_RESERVE, $urandom_range(15));
			end else begin
				if (enabled != 0 && $urandom_range(99) < 80)
					slot = $urandom_range(enabled, 1);
				else
					slot = $urandom_range(15);
				add_req(FUNC_CANCEL, slot);
			end
		end
	endtask

	// Per-phase plans for the random part: slot count, share of reserves and
	// idling mode (none, sender idle, receiver stalling, both).
	int cfg_plan     [8] = '{8, 1, 0, 15, 3, 6, 2, 8};
	int reserve_plan [8] = '{55, 70, 60, 50, 65, 40, 75, 45};
	int send_plan    [4] = '{0, 56, 0, 34};
	int recv_plan    [4] = '{0, 0, 56, 34};

	initial begin
		slots_cfg  = CFG_RESET;
		wait_rd    = 0;
		wait_wr    = 0;
		wait_len   = 0;
		id_next    = ID_W'(1);
		for (int i = 0; i < SLOTS; i++)
			seat_owner[i] = '0;
		for (int i = 0; i < 6; i++)
			n_status[i] = 0;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part, at the reset setting of five slots: fill every
		// enabled slot, overflow one request onto the waitlist, then cancel
		// outside the range (slot zero, the top of the field, just past the
		// enabled count), cancel a booked slot so the waiter takes it over,
		// cancel it again with nobody waiting, cancel the now free slot, and
		// reserve once more to reuse it.
		for (int k = 0; k < 5; k++)
			add_req(FUNC_RESERVE, k);
		add_req(FUNC_RESERVE, 15);
		add_req(FUNC_CANCEL, 0);
		add_req(FUNC_CANCEL, 15);
		add_req(FUNC_CANCEL, 6);
		add_req(FUNC_CANCEL, 3);
		add_req(FUNC_CANCEL, 3);
		add_req(FUNC_CANCEL, 3);
		add_req(FUNC_RESERVE, 0);

		// No slot enabled: every cancel is invalid, reserves queue up.
		set_slots(0);
		add_req(FUNC_CANCEL, 1);
		add_req(FUNC_RESERVE, 0);
		// Beyond the build: behaves as all eight slots.
		set_slots(15);
		add_req(FUNC_RESERVE, 0);
		add_req(FUNC_CANCEL, 8);
		add_req(FUNC_CANCEL, 9);
		// Shrunk to three: slot five stays booked but cannot be cancelled.
		set_slots(3);
		add_req(FUNC_CANCEL, 5);
		add_req(FUNC_CANCEL, 2);
		add_req(FUNC_RESERVE, 0);

		// Random part, eight phases of about eighty requests each.
		for (int ph = 0; ph < 8; ph++) begin
			set_slots(cfg_plan[ph]);
			send_idle_pct  = send_plan[ph % 4];
			recv_stall_pct = recv_plan[ph % 4];
			if (ph == 0) begin
				// Receiver holds off for a long stretch while requests keep
				// coming, so the allocator fills up and stalls its input.
				hold_asks++;
			end
			if (ph == 5) begin
				// Sender stops mid-phase until every result is back.
				add_random(40, reserve_plan[ph]);
				drain();
				add_random(40, reserve_plan[ph]);
			end else begin
				add_random(80, reserve_plan[ph]);
			end
		end

		// Stray results after the last one expected are caught by the
		// monitor during the settling time.
		drain();
		repeat (SETTLE_CYCLES) @(negedge clk);

		$display("Checked %0d results across %0d slot-count settings: %0d seated, %0d queued.",
			n_checked, n_cfg_writes, n_status[STAT_SEATED], n_status[STAT_WAITLISTED]);
		$display("Rejected %0d, cancelled %0d, invalid %0d, free %0d, input stalls %0d.",
			n_status[STAT_REJECTED], n_status[STAT_CANCELLED], n_status[STAT_INVALID],
			n_status[STAT_NOT_BOOKED], n_in_stalls);
		if (n_fail == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
